### sv/gca_pkg.sv
// Shared types, constants and command/status structs of the greedy channel assigner.
`timescale 1ns / 1ps

package gca_pkg;

   localparam int NUM_ARMS_DEF = 4;
   localparam int NUM_REGS     = 4;
   localparam int REG_IDX_W    = 2;
   localparam int ARM_IDX_W    = 3;
   localparam int PROB_W       = 16;
   localparam int REW_W        = 16;
   localparam int IDLE_W       = 17;
   localparam int LOAD_W       = 24;
   localparam int OUT_W        = 19;
   localparam int SCORE_W      = 59;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 24;
   localparam int DIV_STEPS    = 24;
   localparam int DIV_CNT_W    = 5;

   localparam logic [IDLE_W-1:0] ONE_Q16  = 17'd65536;
   localparam logic [LOAD_W-1:0] LOAD_MAX = 24'hFFFFFF;
   localparam logic [OUT_W-1:0]  OUT_MAX  = 19'h7FFFF;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCORE_A,
      OP_SCORE_B,
      OP_CMP,
      OP_SINGLE_A,
      OP_SINGLE_B,
      OP_SINGLE_W,
      OP_IDLE_W,
      OP_LOAD_W,
      OP_SUM,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCORE_A,
      ST_SCORE_B,
      ST_CMP,
      ST_SINGLE_A,
      ST_SINGLE_B,
      ST_SINGLE_W,
      ST_IDLE_W,
      ST_DIV_WAIT,
      ST_SUM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      op_type               op;
      logic [ARM_IDX_W-1:0] arm;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last;
      logic out_free;
   } sts_type;

endpackage

### sv/gca_div.sv
// Restoring radix-2 divider for p*65536/(65536-p), saturated to 24 bits.
`timescale 1ns / 1ps

module gca_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gca_pkg::PROB_W-1:0]    prob,
   output logic                          done,
   output logic [gca_pkg::LOAD_W-1:0]    quot
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [gca_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [gca_pkg::IDLE_W-1:0]     comp_ff;
   logic [gca_pkg::IDLE_W-1:0]     rem_ff;
   logic [gca_pkg::LOAD_W-1:0]     sh_ff;
   logic                           sat_ff;

   logic [gca_pkg::IDLE_W-1:0]     comp_w;
   logic [gca_pkg::IDLE_W:0]       rem2;
   logic [gca_pkg::IDLE_W:0]       diff;
   logic                           ge;
   logic [gca_pkg::IDLE_W-1:0]     rem_in;

   always_comb begin
      comp_w = gca_pkg::ONE_Q16 - {1'b0, prob};
      rem2   = {rem_ff, sh_ff[gca_pkg::LOAD_W-1]};
      diff   = rem2 - {1'b0, comp_ff};
      ge     = (rem2 >= {1'b0, comp_ff});
      rem_in = ge ? diff[gca_pkg::IDLE_W-1:0] : rem2[gca_pkg::IDLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= gca_pkg::DIV_CNT_W'(gca_pkg::DIV_STEPS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == gca_pkg::DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Quotient bits above 23 are zero exactly when p/256 < 65536-p; the
   // remainder then starts as p/256 and 24 steps give the rest.
   always_ff @(posedge clock) begin
      if (start) begin
         comp_ff <= comp_w;
         rem_ff  <= {9'b0, prob[15:8]};
         sh_ff   <= {prob[7:0], 16'b0};
         sat_ff  <= ({9'b0, prob[15:8]} >= comp_w);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= {sh_ff[gca_pkg::LOAD_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = sat_ff ? gca_pkg::LOAD_MAX : sh_ff;

endmodule

### sv/gca_dp.sv
// Datapath: reward registers, per-arm state, shared multiplier steps and result register.
`timescale 1ns / 1ps

module gca_dp #(
   parameter int NUM_ARMS = gca_pkg::NUM_ARMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gca_pkg::cmd_type                  cmd,
   output gca_pkg::sts_type                  sts,
   input  logic [gca_pkg::PROB_W-1:0]        in_prob,
   input  logic                              in_last,
   input  logic                              csr_we,
   input  logic [gca_pkg::REG_IDX_W-1:0]     csr_addr,
   input  logic [gca_pkg::REW_W-1:0]         csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gca_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int ARM_W = $clog2(NUM_ARMS);
   localparam int SUM_W = gca_pkg::REW_W + gca_pkg::IDLE_W + ARM_W;
   localparam int SH_W  = SUM_W - 16;

   logic [gca_pkg::REW_W-1:0]    rew_ff    [gca_pkg::NUM_REGS];
   logic [gca_pkg::IDLE_W-1:0]   idle_ff   [NUM_ARMS];
   logic [gca_pkg::LOAD_W-1:0]   load_ff   [NUM_ARMS];
   logic [gca_pkg::IDLE_W-1:0]   single_ff [NUM_ARMS];

   logic [gca_pkg::PROB_W-1:0]   prob_ff;
   logic                         last_ff;
   logic [32:0]                  t_ff;
   logic [32:0]                  u_ff;
   logic signed [gca_pkg::SCORE_W-1:0] score_ff;
   logic signed [gca_pkg::SCORE_W-1:0] best_score_ff;
   logic [ARM_W-1:0]             best_ff;
   logic [SUM_W-1:0]             acc_ff;
   logic                         rsp_valid_ff;
   logic [gca_pkg::ARM_IDX_W-1:0] rsp_arm_ff;
   logic [gca_pkg::OUT_W-1:0]    rsp_exp_ff;
   logic                         rsp_last_ff;

   logic [ARM_W-1:0]             arm_idx;
   logic [ARM_W-1:0]             rd_idx;
   logic [gca_pkg::ARM_IDX_W-1:0] arm3;
   logic [gca_pkg::REW_W-1:0]    rew_sel;
   logic [gca_pkg::IDLE_W-1:0]   idle_rd;
   logic [gca_pkg::LOAD_W-1:0]   load_rd;
   logic [gca_pkg::IDLE_W-1:0]   single_rd;
   logic [gca_pkg::IDLE_W-1:0]   comp;
   logic signed [24:0]           factor;
   logic signed [gca_pkg::SCORE_W-1:0] sc_a;
   logic signed [gca_pkg::SCORE_W-1:0] sc_b;
   logic signed [gca_pkg::SCORE_W-1:0] score_in;
   logic [32:0]                  idle_prod;
   logic [33:0]                  ssum;
   logic [17:0]                  s_sh;
   logic [gca_pkg::IDLE_W-1:0]   single_in;
   logic [gca_pkg::IDLE_W-1:0]   idle_in;
   logic [24:0]                  lsum;
   logic [gca_pkg::LOAD_W-1:0]   load_in;
   logic [32:0]                  sum_prod;
   logic [SH_W-1:0]              acc_sh;
   logic [gca_pkg::OUT_W-1:0]    exp_in;
   logic                         div_done;
   logic [gca_pkg::LOAD_W-1:0]   div_q;
   logic                         clear_all;

   gca_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == gca_pkg::OP_LOAD),
      .prob  (in_prob),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      arm_idx = cmd.arm[ARM_W-1:0];
      rd_idx  = (cmd.op inside {gca_pkg::OP_SCORE_A, gca_pkg::OP_SCORE_B, gca_pkg::OP_SUM})
                ? arm_idx : best_ff;
      arm3    = gca_pkg::ARM_IDX_W'(arm_idx);
      // arms without a register carry zero reward
      rew_sel = (arm3 < gca_pkg::ARM_IDX_W'(gca_pkg::NUM_REGS))
                ? rew_ff[arm3[gca_pkg::REG_IDX_W-1:0]] : '0;
      idle_rd   = idle_ff[rd_idx];
      load_rd   = load_ff[rd_idx];
      single_rd = single_ff[rd_idx];
      comp      = gca_pkg::ONE_Q16 - {1'b0, prob_ff};

      factor   = $signed({8'b0, gca_pkg::ONE_Q16}) - $signed({1'b0, load_rd});
      sc_a     = $signed({26'b0, t_ff});
      sc_b     = $signed({{34{factor[24]}}, factor});
      score_in = sc_a * sc_b;

      idle_prod = 33'(idle_rd) * 33'(comp);
      idle_in   = idle_prod[32:16];

      ssum      = 34'(t_ff) + 34'(u_ff);
      s_sh      = ssum[33:16];
      single_in = (s_sh > 18'(gca_pkg::ONE_Q16)) ? gca_pkg::ONE_Q16
                                                 : s_sh[gca_pkg::IDLE_W-1:0];

      lsum    = 25'(load_rd) + 25'(div_q);
      load_in = lsum[24] ? gca_pkg::LOAD_MAX : lsum[gca_pkg::LOAD_W-1:0];

      sum_prod = 33'(rew_sel) * 33'(single_rd);
      acc_sh   = acc_ff[SUM_W-1:16];
      exp_in   = (acc_sh > SH_W'(gca_pkg::OUT_MAX)) ? gca_pkg::OUT_MAX
                                                    : gca_pkg::OUT_W'(acc_sh);

      clear_all = (cmd.op == gca_pkg::OP_EMIT) && last_ff;
   end

   // reward registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gca_pkg::NUM_REGS; i++) begin
            rew_ff[i] <= '0;
         end
      end else if (csr_we) begin
         rew_ff[csr_addr] <= csr_wdata;
      end
   end

   // per-arm state, back to its reset values after the last node
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < NUM_ARMS; i++) begin
            idle_ff[i]   <= gca_pkg::ONE_Q16;
            load_ff[i]   <= '0;
            single_ff[i] <= '0;
         end
      end else begin
         case (cmd.op)
            gca_pkg::OP_SINGLE_W: single_ff[best_ff] <= single_in;
            gca_pkg::OP_IDLE_W:   idle_ff[best_ff]   <= idle_in;
            gca_pkg::OP_LOAD_W:   load_ff[best_ff]   <= load_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         gca_pkg::OP_LOAD: begin
            prob_ff <= in_prob;
            last_ff <= in_last;
            acc_ff  <= '0;
         end
         gca_pkg::OP_SCORE_A: t_ff <= 33'(rew_sel) * 33'(idle_rd);
         gca_pkg::OP_SCORE_B: score_ff <= score_in;
         gca_pkg::OP_CMP: begin
            if ((arm_idx == '0) || (score_ff >= best_score_ff)) begin
               best_score_ff <= score_ff;
               best_ff       <= arm_idx;
            end
         end
         gca_pkg::OP_SINGLE_A: t_ff <= 33'(single_rd) * 33'(comp);
         gca_pkg::OP_SINGLE_B: u_ff <= 33'(idle_rd) * 33'(prob_ff);
         gca_pkg::OP_SUM:      acc_ff <= acc_ff + SUM_W'(sum_prod);
         gca_pkg::OP_EMIT: begin
            rsp_arm_ff  <= gca_pkg::ARM_IDX_W'(best_ff);
            rsp_exp_ff  <= last_ff ? exp_in : '0;
            rsp_last_ff <= last_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == gca_pkg::OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.div_done = div_done;
   assign sts.last     = last_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b0, rsp_exp_ff, rsp_arm_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### sv/gca_ctrl.sv
// Controller: sequences scan, update, divide wait, summation and result hand-off.
`timescale 1ns / 1ps

module gca_ctrl #(
   parameter int NUM_ARMS = gca_pkg::NUM_ARMS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gca_pkg::sts_type  sts,
   output gca_pkg::cmd_type  cmd
);

   localparam int ARM_W = $clog2(NUM_ARMS);

   gca_pkg::state_type state_ff, state_in;
   logic [ARM_W-1:0]   cnt_ff, cnt_in;
   logic               cnt_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gca_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cnt_end  = (cnt_ff == ARM_W'(NUM_ARMS - 1));
      in_ready = 1'b0;
      cmd.op   = gca_pkg::OP_NONE;
      cmd.arm  = gca_pkg::ARM_IDX_W'(cnt_ff);
      case (state_ff)
         gca_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.op   = gca_pkg::OP_LOAD;
               cnt_in   = '0;
               state_in = gca_pkg::ST_SCORE_A;
            end
         end
         gca_pkg::ST_SCORE_A: begin
            cmd.op   = gca_pkg::OP_SCORE_A;
            state_in = gca_pkg::ST_SCORE_B;
         end
         gca_pkg::ST_SCORE_B: begin
            cmd.op   = gca_pkg::OP_SCORE_B;
            state_in = gca_pkg::ST_CMP;
         end
         gca_pkg::ST_CMP: begin
            cmd.op = gca_pkg::OP_CMP;
            if (cnt_end) begin
               state_in = gca_pkg::ST_SINGLE_A;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = gca_pkg::ST_SCORE_A;
            end
         end
         gca_pkg::ST_SINGLE_A: begin
            cmd.op   = gca_pkg::OP_SINGLE_A;
            state_in = gca_pkg::ST_SINGLE_B;
         end
         gca_pkg::ST_SINGLE_B: begin
            cmd.op   = gca_pkg::OP_SINGLE_B;
            state_in = gca_pkg::ST_SINGLE_W;
         end
         gca_pkg::ST_SINGLE_W: begin
            cmd.op   = gca_pkg::OP_SINGLE_W;
            state_in = gca_pkg::ST_IDLE_W;
         end
         gca_pkg::ST_IDLE_W: begin
            cmd.op   = gca_pkg::OP_IDLE_W;
            state_in = gca_pkg::ST_DIV_WAIT;
         end
         gca_pkg::ST_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.op = gca_pkg::OP_LOAD_W;
               cnt_in = '0;
               state_in = sts.last ? gca_pkg::ST_SUM : gca_pkg::ST_EMIT;
            end
         end
         gca_pkg::ST_SUM: begin
            cmd.op = gca_pkg::OP_SUM;
            if (cnt_end) begin
               state_in = gca_pkg::ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         gca_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.op   = gca_pkg::OP_EMIT;
               state_in = gca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gca_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/greedy_channel_assigner_unit.sv
// Top level of the greedy channel assigner: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Takes one node word at a time (transmit probability in Q0.16, tlast on the
// final node of a set) and returns one word per node: the arm it was given and,
// on the final node, the expected mean reward in Q3.16 (zero otherwise). Arm
// scores are reward * idle * (1 - load), highest arm index wins a tie. A word
// is worked on alone: the score scan steps through the arms one at a time,
// then the chosen arm's single and idle values are updated, while a 24-step
// restoring divider computes p/(1-p) alongside; once it is done the chosen
// arm's load is updated, and on the final node a summation over all arms
// follows. The result sits in an output register, so the next word is taken
// while it waits; if it is still unclaimed when the next result is ready, the
// block holds there. After the final node all arm state returns to its reset
// values. Reward registers are written through csr_*; the user must write them
// only while the block is idle, as the block itself does not enforce it.
module greedy_channel_assigner_unit #(
   parameter int NUM_ARMS = gca_pkg::NUM_ARMS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gca_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [15:0] node_prob
   input  logic                               req_tlast,   // last_node
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gca_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [2:0] chosen_arm,
                                                           // [21:3] expected_reward
   output logic                               rsp_tlast,   // result_last
   input  logic                               csr_we,
   input  logic [gca_pkg::REG_IDX_W-1:0]      csr_addr,    // arm_reward_0..3
   input  logic [gca_pkg::REW_W-1:0]          csr_wdata
);

   gca_pkg::cmd_type cmd;
   gca_pkg::sts_type sts;

   gca_ctrl #(
      .NUM_ARMS (NUM_ARMS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   gca_dp #(
      .NUM_ARMS (NUM_ARMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_prob    (req_tdata[gca_pkg::PROB_W-1:0]),
      .in_last    (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### sv/gca_checker.sv
// Port-level checks of the greedy channel assigner, bound to the top level.
`timescale 1ns / 1ps

module gca_checker #(
   parameter int NUM_ARMS = gca_pkg::NUM_ARMS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [gca_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // one node in flight: no accept right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   a_arm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] < NUM_ARMS)
      else $error("chosen arm out of range");

   a_reward_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[21:3] == '0)
      else $error("expected reward nonzero on a non-final node");

endmodule

bind greedy_channel_assigner_unit gca_checker #(.NUM_ARMS(NUM_ARMS)) u_gca_checker (.*);
